[rtl/core/dltq_pkg.sv]
`timescale 1ns / 1ps

package dltq_pkg;

  localparam int KeyW     = 8;
  localparam int DelayInW = 16;
  localparam int StatusW  = 3;

  // result codes
  typedef enum logic [StatusW-1:0] {
    ST_STARTED   = 3'd0,
    ST_CANCELLED = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_NONE      = 3'd6,
    ST_EMPTY     = 3'd7
  } status_e;

  // what a token does when it reaches a cell
  typedef enum logic [1:0] {
    TOK_SEEK_INS,
    TOK_PUSH,
    TOK_SEEK_DEL,
    TOK_PULL
  } tok_mode_e;

  typedef struct packed {
    logic            valid;
    tok_mode_e       mode;
    logic [KeyW-1:0] key;
  } tok_t;

  // broadcast commands for the whole row
  typedef struct packed {
    logic shift;
    logic dec;
  } cell_cmd_t;

endpackage

[rtl/core/dltq_cell.sv]
`timescale 1ns / 1ps

module dltq_cell #(
  parameter int DELAY_BITS = 16,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CNT_W-1:0]         count_i,
  input  dltq_pkg::cell_cmd_t      cmd_i,
  input  logic [dltq_pkg::KeyW-1:0] req_key_i,
  input  dltq_pkg::tok_t           tok_i,
  input  logic [DELAY_BITS-1:0]    tok_val_i,
  input  logic [dltq_pkg::KeyW-1:0] nb_key_i,
  input  logic [DELAY_BITS-1:0]    nb_delta_i,
  output logic [dltq_pkg::KeyW-1:0] key_o,
  output logic [DELAY_BITS-1:0]    delta_o,
  output logic                     match_o,
  output dltq_pkg::tok_t           tok_o,
  output logic [DELAY_BITS-1:0]    tok_val_o,
  output logic                     done_o,
  output logic                     busy_o
);

  logic [dltq_pkg::KeyW-1:0] key_q, key_d;
  logic [DELAY_BITS-1:0]     delta_q, delta_d;
  dltq_pkg::tok_t            tok_q;
  logic [DELAY_BITS-1:0]     tok_val_q;
  logic                      occ;
  logic                      nb_occ;

  assign occ     = CNT_W'(INDEX) < count_i;
  assign nb_occ  = CNT_W'(INDEX + 1) < count_i;
  assign key_o   = key_q;
  assign delta_o = delta_q;
  assign match_o = occ && (key_q == req_key_i);
  assign busy_o  = tok_q.valid;

  always_comb begin
    key_d     = key_q;
    delta_d   = delta_q;
    tok_o     = '0;
    tok_val_o = '0;
    done_o    = 1'b0;

    if (cmd_i.shift) begin
      key_d   = nb_key_i;
      delta_d = nb_delta_i;
    end else if (cmd_i.dec && (INDEX == 0) && (delta_q != '0)) begin
      delta_d = delta_q - 1'b1;
    end

    if (tok_q.valid) begin
      unique case (tok_q.mode)
        dltq_pkg::TOK_SEEK_INS: begin
          if (!occ) begin
            key_d   = tok_q.key;
            delta_d = tok_val_q;
            done_o  = 1'b1;
          end else if (tok_val_q > delta_q) begin
            // keep walking with the remaining time
            tok_o     = '{valid: 1'b1, mode: dltq_pkg::TOK_SEEK_INS, key: tok_q.key};
            tok_val_o = tok_val_q - delta_q;
          end else begin
            // new entry lands here, old one moves right with reduced delta
            key_d     = tok_q.key;
            delta_d   = tok_val_q;
            tok_o     = '{valid: 1'b1, mode: dltq_pkg::TOK_PUSH, key: key_q};
            tok_val_o = delta_q - tok_val_q;
          end
        end
        dltq_pkg::TOK_PUSH: begin
          key_d   = tok_q.key;
          delta_d = tok_val_q;
          if (occ) begin
            tok_o     = '{valid: 1'b1, mode: dltq_pkg::TOK_PUSH, key: key_q};
            tok_val_o = delta_q;
          end else begin
            done_o = 1'b1;
          end
        end
        dltq_pkg::TOK_SEEK_DEL: begin
          if (occ && (key_q == tok_q.key)) begin
            if (nb_occ) begin
              // fold this delta into the successor, then close the gap
              key_d   = nb_key_i;
              delta_d = nb_delta_i + delta_q;
              tok_o   = '{valid: 1'b1, mode: dltq_pkg::TOK_PULL, key: '0};
            end else begin
              done_o = 1'b1;
            end
          end else begin
            tok_o = '{valid: 1'b1, mode: dltq_pkg::TOK_SEEK_DEL, key: tok_q.key};
          end
        end
        dltq_pkg::TOK_PULL: begin
          if (nb_occ) begin
            key_d   = nb_key_i;
            delta_d = nb_delta_i;
            tok_o   = '{valid: 1'b1, mode: dltq_pkg::TOK_PULL, key: '0};
          end else begin
            done_o = 1'b1;
          end
        end
        default: begin
          done_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    delta_q   <= delta_d;
    tok_val_q <= tok_val_i;
  end

endmodule

[rtl/core/delta_list_timer_queue_core.sv]
`timescale 1ns / 1ps
// tick: expired timers pass S_TICK_DEC and S_TICK_POP into the output register, then leave
// one per cycle as the output frees; tick with nothing expired: S_TICK_DEC, S_TICK_POP, S_FINISH
// tick on an empty queue: S_TICK_DEC, S_FINISH; start/cancel: token walks the cell row one cell
// a cycle, result via S_FINISH once the walk is done; duplicate, full and not found use S_REQ, S_FINISH
// one request in flight; next request taken the cycle after its last result is registered
// reset clears the timer count, walking tokens and the output register; cell keys and
// deltas need no clearing pass, only occupied cells are read

module delta_list_timer_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DELAY_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [dltq_pkg::KeyW-1:0]      timer_key_i,
  input  logic [dltq_pkg::DelayInW-1:0]  delay_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dltq_pkg::StatusW-1:0]   status_o,
  output logic [dltq_pkg::KeyW-1:0]      expired_key_o,
  output logic                           last_o
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int WideW = (DELAY_BITS > dltq_pkg::DelayInW) ? DELAY_BITS : dltq_pkg::DelayInW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ,
    S_TICK_DEC,
    S_TICK_POP,
    S_INS_WALK,
    S_DEL_WALK,
    S_FINISH
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [dltq_pkg::KeyW-1:0] req_key_q, req_key_d;
  logic [DELAY_BITS-1:0]     req_delay_q, req_delay_d;
  dltq_pkg::status_e         res_status_q, res_status_d;
  logic [dltq_pkg::KeyW-1:0] res_key_q, res_key_d;
  logic                      out_valid_q, out_valid_d;
  dltq_pkg::status_e         out_status_q, out_status_d;
  logic [dltq_pkg::KeyW-1:0] out_key_q, out_key_d;
  logic                      out_last_q, out_last_d;

  // cell row wiring; tok_chain[0] is the launch slot
  dltq_pkg::tok_t            tok_chain [DEPTH+1];
  logic [DELAY_BITS-1:0]     tok_val_chain [DEPTH+1];
  logic [dltq_pkg::KeyW-1:0] key_arr [DEPTH];
  logic [DELAY_BITS-1:0]     delta_arr [DEPTH];
  logic [DEPTH-1:0]          match_vec;
  logic [DEPTH-1:0]          done_vec;
  logic [DEPTH-1:0]          busy_vec;
  dltq_pkg::cell_cmd_t       cmd;
  dltq_pkg::tok_t            launch_tok;
  logic [DELAY_BITS-1:0]     launch_val;

  logic                      out_free;
  logic                      match_any;
  logic                      chain_done;
  logic                      pop_last;
  logic [WideW-1:0]          delay_wide;
  logic [DELAY_BITS-1:0]     delay_sat;

  // cap requested delay at the largest storable value
  assign delay_wide = WideW'(delay_i);
  assign delay_sat  = (delay_wide > WideW'({DELAY_BITS{1'b1}})) ? {DELAY_BITS{1'b1}}
                                                                 : delay_wide[DELAY_BITS-1:0];

  assign match_any  = |match_vec;
  assign chain_done = |done_vec;
  assign out_free   = !out_valid_q || out_ready_i;
  // popped entry is the last when nothing remains or its successor is still pending
  assign pop_last   = (count_q == CntW'(1)) || (delta_arr[1] != '0);

  // token launched into the first cell
  assign tok_chain[0]     = launch_tok;
  assign tok_val_chain[0] = launch_val;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [dltq_pkg::KeyW-1:0] nb_key;
      logic [DELAY_BITS-1:0]     nb_delta;

      if (i < DEPTH - 1) begin : g_nb
        assign nb_key   = key_arr[i+1];
        assign nb_delta = delta_arr[i+1];
      end else begin : g_end
        assign nb_key   = '0;
        assign nb_delta = '0;
      end

      dltq_cell #(
        .DELAY_BITS (DELAY_BITS),
        .CNT_W      (CntW),
        .INDEX      (i)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .count_i    (count_q),
        .cmd_i      (cmd),
        .req_key_i  (req_key_q),
        .tok_i      (tok_chain[i]),
        .tok_val_i  (tok_val_chain[i]),
        .nb_key_i   (nb_key),
        .nb_delta_i (nb_delta),
        .key_o      (key_arr[i]),
        .delta_o    (delta_arr[i]),
        .match_o    (match_vec[i]),
        .tok_o      (tok_chain[i+1]),
        .tok_val_o  (tok_val_chain[i+1]),
        .done_o     (done_vec[i]),
        .busy_o     (busy_vec[i])
      );
    end
  endgenerate

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    req_key_d    = req_key_q;
    req_delay_d  = req_delay_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_last_d   = out_last_q;
    cmd          = '0;
    launch_tok   = '0;
    launch_val   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_key_d   = timer_key_i;
          req_delay_d = delay_sat;
          state_d     = action_i ? S_TICK_DEC : S_REQ;
        end
      end
      S_REQ: begin
        if (req_delay_q != '0) begin
          // start: duplicate check wins over full
          if (match_any) begin
            res_status_d = dltq_pkg::ST_DUPLICATE;
            res_key_d    = req_key_q;
            state_d      = S_FINISH;
          end else if (count_q == CntW'(DEPTH)) begin
            res_status_d = dltq_pkg::ST_FULL;
            res_key_d    = req_key_q;
            state_d      = S_FINISH;
          end else begin
            launch_tok = '{valid: 1'b1, mode: dltq_pkg::TOK_SEEK_INS, key: req_key_q};
            launch_val = req_delay_q;
            state_d    = S_INS_WALK;
          end
        end else begin
          // cancel
          if (!match_any) begin
            res_status_d = dltq_pkg::ST_NOT_FOUND;
            res_key_d    = req_key_q;
            state_d      = S_FINISH;
          end else begin
            launch_tok = '{valid: 1'b1, mode: dltq_pkg::TOK_SEEK_DEL, key: req_key_q};
            state_d    = S_DEL_WALK;
          end
        end
      end
      S_TICK_DEC: begin
        if (count_q == '0) begin
          res_status_d = dltq_pkg::ST_EMPTY;
          res_key_d    = '0;
          state_d      = S_FINISH;
        end else begin
          cmd.dec = 1'b1;
          state_d = S_TICK_POP;
        end
      end
      S_TICK_POP: begin
        if (delta_arr[0] == '0) begin
          // pop the head, one per cycle, as the output frees up
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = dltq_pkg::ST_EXPIRED;
            out_key_d    = key_arr[0];
            out_last_d   = pop_last;
            cmd.shift    = 1'b1;
            count_d      = count_q - 1'b1;
            if (pop_last) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          res_status_d = dltq_pkg::ST_NONE;
          res_key_d    = '0;
          state_d      = S_FINISH;
        end
      end
      S_INS_WALK: begin
        if (chain_done) begin
          count_d      = count_q + 1'b1;
          res_status_d = dltq_pkg::ST_STARTED;
          res_key_d    = req_key_q;
          state_d      = S_FINISH;
        end
      end
      S_DEL_WALK: begin
        if (chain_done) begin
          count_d      = count_q - 1'b1;
          res_status_d = dltq_pkg::ST_CANCELLED;
          res_key_d    = req_key_q;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_key_d    = res_key_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      req_key_q    <= '0;
      req_delay_q  <= '0;
      res_status_q <= dltq_pkg::ST_STARTED;
      res_key_q    <= '0;
      out_status_q <= dltq_pkg::ST_STARTED;
      out_key_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      req_key_q    <= req_key_d;
      req_delay_q  <= req_delay_d;
      res_status_q <= res_status_d;
      res_key_q    <= res_key_d;
      out_status_q <= out_status_d;
      out_key_q    <= out_key_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign expired_key_o = out_key_q;
  assign last_o        = out_last_q;

  // occupancy never runs past the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("timer count exceeds depth");

  // count moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
    else $error("timer count jumped");

  // keys stay unique among live cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("duplicate key in queue");

  // tokens live only during a walk, and never fall off the end of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INS_WALK && state_q != S_DEL_WALK) |-> (busy_vec == '0))
    else $error("stray token in cell row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok_chain[DEPTH].valid && $onehot0(done_vec))
    else $error("token ran past last cell or finished twice");

endmodule
